// File: design/gmc_pkg.sv
package gmc_pkg;

    // Pipeline depth: input register, five work stages, result register.
    localparam int NSTG    = 7;
    localparam int STG_IN  = 0;
    localparam int STG_OUT = NSTG - 1;

    // Field widths of the request and result transactions.
    localparam int YEAR_IN_W   = 19;
    localparam int MONTH_W     = 4;
    localparam int DAY_IN_W    = 6;
    localparam int MJD_W       = 31;
    localparam int STATUS_W    = 3;
    localparam int YEAR_OUT_W  = 23;
    localparam int DAY_OUT_W   = 5;

    localparam int NUM_MONTHS  = 12;
    localparam int MSTART_W    = 9;
    localparam int MLEN_W      = 5;

    // Date to day number.
    localparam int X_W       = 19;
    localparam int K100      = 26;
    localparam int M100_W    = 20;
    localparam longint unsigned M100 = ((64'd1 << K100) + 64'd99) / 64'd100;
    localparam int Q_W       = 12;
    localparam int T1_W      = 29;

    // Day number to date.
    localparam int JD_W      = 30;
    localparam int X1_W      = 32;
    localparam int K1        = 50;
    localparam int M1_W      = 33;
    localparam longint unsigned M1 = ((64'd1 << K1) + 64'd146096) / 64'd146097;
    localparam int A_W       = 15;
    localparam int K2        = 43;
    localparam int M2_W      = 33;
    localparam longint unsigned M2 = ((64'd1 << K2) + 64'd1460) / 64'd1461;
    localparam int U_W       = 22;
    localparam int R_W       = 11;
    localparam int S_W       = 9;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_YEAR  = 3'd1,
        ST_BAD_MONTH = 3'd2,
        ST_BAD_DAY   = 3'd3,
        ST_RANGE     = 3'd4
    } t_status;

    typedef struct packed {
        logic [NSTG-1:0] en;      // load enable per pipeline register
        logic            in_rdy;
        logic            out_vld;
        logic            req;     // request type entering the result register
    } t_pipe_ctl;

    // First day of each month, counted from March 1 (index 0 is March).
    function automatic logic [MSTART_W-1:0] f_month_start(input logic [MONTH_W-1:0] idx);
        logic [MSTART_W-1:0] v;
        unique case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // Month length in a common year, January is 1.
    function automatic logic [MLEN_W-1:0] f_month_len(input logic [MONTH_W-1:0] month);
        logic [MLEN_W-1:0] v;
        unique case (month)
            4'd2:    v = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: v = 5'd30;
            default: v = 5'd31;
        endcase
        return v;
    endfunction

endpackage

// File: design/gmc_if.sv
interface gmc_req_if;
    import gmc_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic signed [YEAR_IN_W-1:0] in_year;
    logic [MONTH_W-1:0]          in_month;
    logic [DAY_IN_W-1:0]         in_day;
    logic signed [MJD_W-1:0]     in_mjd;

    modport source (output valid, req_type, in_year, in_month, in_day, in_mjd,
                    input ready);
    modport sink   (input valid, req_type, in_year, in_month, in_day, in_mjd,
                    output ready);
endinterface

interface gmc_rsp_if;
    import gmc_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [STATUS_W-1:0]          status;
    logic signed [MJD_W-1:0]      out_mjd;
    logic signed [YEAR_OUT_W-1:0] out_year;
    logic [MONTH_W-1:0]           out_month;
    logic [DAY_OUT_W-1:0]         out_day;

    modport source (output valid, status, out_mjd, out_year, out_month, out_day,
                    input ready);
    modport sink   (input valid, status, out_mjd, out_year, out_month, out_day,
                    output ready);
endinterface

// File: design/gmc_ctl.sv
module gmc_ctl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_req,
    input  logic               i_out_ready,
    output gmc_pkg::t_pipe_ctl o_ctl
);
    import gmc_pkg::*;

    logic [NSTG-1:0]    r_vld;
    logic [STG_OUT-1:0] r_req;
    logic [NSTG:0]      en;

    // A stage loads when it is empty or when its content moves on this cycle.
    always_comb begin
        en[NSTG] = i_out_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_req[0] <= i_in_req;
        end
        for (int k = 1; k < STG_OUT; k++) begin
            if (en[k]) begin
                r_req[k] <= r_req[k-1];
            end
        end
    end

    assign o_ctl.en      = en[NSTG-1:0];
    assign o_ctl.in_rdy  = en[0];
    assign o_ctl.out_vld = r_vld[STG_OUT];
    assign o_ctl.req     = r_req[STG_OUT-1];

endmodule

// File: design/gmc_d2m.sv
module gmc_d2m (
    input  logic                                 i_clk,
    input  logic [gmc_pkg::NSTG-1:0]             i_en,
    input  logic signed [gmc_pkg::YEAR_IN_W-1:0] i_year,
    input  logic [gmc_pkg::MONTH_W-1:0]          i_month,
    input  logic [gmc_pkg::DAY_IN_W-1:0]         i_day,
    output gmc_pkg::t_status                     o_status,
    output logic signed [gmc_pkg::MJD_W-1:0]     o_mjd
);
    import gmc_pkg::*;

    // Stage 1: range checks, offsets and month table lookups.
    logic signed [YEAR_IN_W:0] ext_year;
    logic signed [YEAR_IN_W:0] sum_x0;
    logic signed [YEAR_IN_W:0] sum_ya;
    logic                      adj;
    logic [MONTH_W-1:0]        mar_idx;

    logic                r_s1_bad_year, r_s1_bad_month, r_s1_adj, r_s1_feb;
    logic [X_W-1:0]      r_s1_x0, r_s1_ya;
    logic [MSTART_W-1:0] r_s1_mterm;
    logic [MLEN_W-1:0]   r_s1_mlen;
    logic [DAY_IN_W-1:0] r_s1_day;

    assign ext_year = {i_year[YEAR_IN_W-1], i_year};
    assign adj      = (i_month < 4'd3);
    // Year + 4800 is a multiple of 400 exactly when the year is.
    assign sum_x0   = ext_year + 20'sd4800;
    assign sum_ya   = ext_year + (adj ? 20'sd4711 : 20'sd4712);
    assign mar_idx  = (i_month >= 4'd3) ? i_month - 4'd3 : i_month + 4'd9;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s1_bad_year  <= (ext_year < -20'sd4699);
            r_s1_bad_month <= (i_month == '0) || (i_month > MONTH_W'(NUM_MONTHS));
            r_s1_adj       <= adj;
            r_s1_feb       <= (i_month == 4'd2);
            r_s1_x0        <= sum_x0[X_W-1:0];
            r_s1_ya        <= sum_ya[X_W-1:0];
            r_s1_mterm     <= f_month_start(mar_idx);
            r_s1_mlen      <= f_month_len(i_month);
            r_s1_day       <= i_day;
        end
    end

    // Stage 2: century quotient by reciprocal, and the 1461-day term.
    logic [X_W+M100_W-1:0] prod100;
    logic [T1_W-1:0]       t1;

    logic                r_s2_bad_year, r_s2_bad_month, r_s2_adj, r_s2_feb;
    logic [Q_W-1:0]      r_s2_q100;
    logic [X_W-1:0]      r_s2_x0;
    logic [T1_W-3:0]     r_s2_t1q;
    logic [MSTART_W-1:0] r_s2_mterm;
    logic [MLEN_W-1:0]   r_s2_mlen;
    logic [DAY_IN_W-1:0] r_s2_day;

    assign prod100 = (X_W+M100_W)'(r_s1_x0) * (X_W+M100_W)'(M100);
    assign t1      = T1_W'(r_s1_ya) * T1_W'(1461);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_s2_bad_year  <= r_s1_bad_year;
            r_s2_bad_month <= r_s1_bad_month;
            r_s2_adj       <= r_s1_adj;
            r_s2_feb       <= r_s1_feb;
            r_s2_q100      <= prod100[K100+Q_W-1:K100];
            r_s2_x0        <= r_s1_x0;
            r_s2_t1q       <= t1[T1_W-1:2];
            r_s2_mterm     <= r_s1_mterm;
            r_s2_mlen      <= r_s1_mlen;
            r_s2_day       <= r_s1_day;
        end
    end

    // Stage 3: leap year, day check and the century correction.
    logic                r100_zero, leap, day_bad;
    logic [MLEN_W-1:0]   len;
    logic [Q_W-1:0]      qq;
    logic [Q_W+1:0]      qq3;
    t_status             n_s3_status;

    t_status             r_s3_status;
    logic [T1_W-3:0]     r_s3_t1q;
    logic [MSTART_W-1:0] r_s3_mterm;
    logic [Q_W-1:0]      r_s3_t3;
    logic [DAY_IN_W-1:0] r_s3_day;

    assign r100_zero = (r_s2_x0 == X_W'(r_s2_q100) * X_W'(100));
    assign leap      = (r_s2_x0[1:0] == 2'b00) && (!r100_zero || (r_s2_q100[1:0] == 2'b00));
    assign len       = (r_s2_feb && leap) ? 5'd29 : r_s2_mlen;
    assign day_bad   = (r_s2_day == '0) || (r_s2_day > DAY_IN_W'(len));
    // The year-adjusted century count differs by one only when the shifted
    // year lands on a century boundary.
    assign qq        = (r_s2_adj && r100_zero) ? r_s2_q100 : r_s2_q100 + 12'd1;
    assign qq3       = {2'b00, qq} + {1'b0, qq, 1'b0};

    always_comb begin
        if (r_s2_bad_year) begin
            n_s3_status = ST_BAD_YEAR;
        end else if (r_s2_bad_month) begin
            n_s3_status = ST_BAD_MONTH;
        end else if (day_bad) begin
            n_s3_status = ST_BAD_DAY;
        end else begin
            n_s3_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_s3_status <= n_s3_status;
            r_s3_t1q    <= r_s2_t1q;
            r_s3_mterm  <= r_s2_mterm;
            r_s3_t3     <= qq3[Q_W+1:2];
            r_s3_day    <= r_s2_day;
        end
    end

    // Stage 4: final sum.
    logic [31:0] mjd_sum;

    t_status                 r_s4_status, r_s5_status;
    logic signed [MJD_W-1:0] r_s4_mjd, r_s5_mjd;

    assign mjd_sum = 32'(r_s3_t1q) + 32'(r_s3_mterm) + 32'(r_s3_day)
                   - 32'(r_s3_t3) - 32'd2399904;

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_s4_status <= r_s3_status;
            if (r_s3_status == ST_BAD_YEAR || r_s3_status == ST_BAD_MONTH) begin
                r_s4_mjd <= '0;
            end else begin
                r_s4_mjd <= mjd_sum[MJD_W-1:0];
            end
        end
        if (i_en[5]) begin
            r_s5_status <= r_s4_status;
            r_s5_mjd    <= r_s4_mjd;
        end
    end

    assign o_status = r_s5_status;
    assign o_mjd    = r_s5_mjd;

endmodule

// File: design/gmc_m2d.sv
module gmc_m2d (
    input  logic                                  i_clk,
    input  logic [gmc_pkg::NSTG-1:0]              i_en,
    input  logic signed [gmc_pkg::MJD_W-1:0]      i_mjd,
    output logic                                  o_range_bad,
    output logic signed [gmc_pkg::YEAR_OUT_W-1:0] o_year,
    output logic [gmc_pkg::MONTH_W-1:0]           o_month,
    output logic [gmc_pkg::DAY_OUT_W-1:0]         o_day
);
    import gmc_pkg::*;

    // Stage 1: range check and the Julian day number.
    logic signed [31:0] ext_mjd;
    logic signed [31:0] jd_full;

    logic            r_s1_rbad;
    logic [JD_W-1:0] r_s1_jd;
    logic [X1_W-1:0] r_s1_x1;

    assign ext_mjd = {i_mjd[MJD_W-1], i_mjd};
    assign jd_full = ext_mjd + 32'sd2400001;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s1_rbad <= (ext_mjd <= -32'sd2395520) || (ext_mjd >= 32'sd1000000000);
            r_s1_jd   <= jd_full[JD_W-1:0];
            r_s1_x1   <= {jd_full[JD_W-1:0], 2'b00} - 32'd17918;
        end
    end

    // Stage 2: Gregorian 400-year cycles by reciprocal multiplication.
    logic [X1_W+M1_W-1:0] prod1;

    logic            r_s2_rbad;
    logic [JD_W-1:0] r_s2_jd;
    logic [A_W-1:0]  r_s2_a;

    assign prod1 = (X1_W+M1_W)'(r_s1_x1) * (X1_W+M1_W)'(M1);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_s2_rbad <= r_s1_rbad;
            r_s2_jd   <= r_s1_jd;
            r_s2_a    <= prod1[K1+A_W-1:K1];
        end
    end

    // Stage 3: fold the skipped leap days back into a Julian-style count.
    logic [A_W+1:0]  a3;
    logic [A_W:0]    b;
    logic [A_W+1:0]  b1;
    logic [A_W:0]    c;

    logic            r_s3_rbad;
    logic [X1_W-1:0] r_s3_v;

    assign a3 = {2'b00, r_s2_a} + {1'b0, r_s2_a, 1'b0};
    assign b  = a3[A_W+1:1];
    assign b1 = {1'b0, b} + 17'd1;
    assign c  = b1[A_W+1:1];

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_s3_rbad <= r_s2_rbad;
            r_s3_v    <= {r_s2_jd, 2'b00} + X1_W'({c, 2'b00}) - 32'd385;
        end
    end

    // Stage 4: four-year cycles by reciprocal multiplication.
    logic [X1_W+M2_W-1:0] prod2;

    logic           r_s4_rbad;
    logic [U_W-1:0] r_s4_u;
    logic [R_W-1:0] r_s4_vlo;

    assign prod2 = (X1_W+M2_W)'(r_s3_v) * (X1_W+M2_W)'(M2);

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_s4_rbad <= r_s3_rbad;
            r_s4_u    <= prod2[K2+U_W-1:K2];
            r_s4_vlo  <= r_s3_v[R_W-1:0];
        end
    end

    // Stage 5: remainder within the four-year cycle and the year.
    // The remainder is below 1461, so its low bits alone determine it.
    logic [R_W-1:0] ulo;
    logic [R_W-1:0] rem;
    logic           carry;

    logic                         r_s5_rbad;
    logic signed [YEAR_OUT_W-1:0] r_s5_year;
    logic [S_W-1:0]               r_s5_s;

    assign ulo   = r_s4_u[R_W-1:0] * 11'd1461;
    assign rem   = r_s4_vlo - ulo;
    assign carry = (rem >= 11'd1224);

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_s5_rbad <= r_s4_rbad;
            r_s5_year <= YEAR_OUT_W'(r_s4_u) + YEAR_OUT_W'(carry) - 23'd4712;
            r_s5_s    <= rem[R_W-1:2];
        end
    end

    // Month and day from the day of the year counted from March 1.
    logic [MONTH_W-1:0]  mi;
    logic [MSTART_W-1:0] dsum;

    always_comb begin
        mi = '0;
        for (int k = 1; k < NUM_MONTHS; k++) begin
            if (r_s5_s >= f_month_start(MONTH_W'(k))) begin
                mi = MONTH_W'(k);
            end
        end
    end

    assign dsum        = r_s5_s - f_month_start(mi) + 9'd1;
    assign o_range_bad = r_s5_rbad;
    assign o_year      = r_s5_year;
    assign o_month     = (mi <= 4'd9) ? mi + 4'd3 : mi - 4'd9;
    assign o_day       = dsum[DAY_OUT_W-1:0];

endmodule

// File: design/gregorian_mjd_converter.sv
// Channel   Role    Payload
// i_req     sink    req_type, in_year, in_month, in_day, in_mjd
// o_rsp     source  status, out_mjd, out_year, out_month, out_day
//
// One transaction per clock is taken and one result per clock is given
// while no result is stalled. A request passes through the input
// register, five work stages that keep each reciprocal multiplier in a stage
// of its own, and the result register.
// Reset clears only the stage valid flags; data registers are not reset.
// A stalled result holds the pipeline, and empty stages keep filling.
module gregorian_mjd_converter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gmc_req_if.sink   i_req,
    gmc_rsp_if.source o_rsp
);
    import gmc_pkg::*;

    t_pipe_ctl ctl;

    gmc_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_in_req    (i_req.req_type),
        .i_out_ready (o_rsp.ready),
        .o_ctl       (ctl)
    );

    assign i_req.ready = ctl.in_rdy;
    assign o_rsp.valid = ctl.out_vld;

    // Input register.
    logic signed [YEAR_IN_W-1:0] r_year;
    logic [MONTH_W-1:0]          r_month;
    logic [DAY_IN_W-1:0]         r_day;
    logic signed [MJD_W-1:0]     r_mjd;

    always_ff @(posedge i_clk) begin
        if (ctl.en[STG_IN]) begin
            r_year  <= i_req.in_year;
            r_month <= i_req.in_month;
            r_day   <= i_req.in_day;
            r_mjd   <= i_req.in_mjd;
        end
    end

    t_status                      d2m_status;
    logic signed [MJD_W-1:0]      d2m_mjd;
    logic                         m2d_rbad;
    logic signed [YEAR_OUT_W-1:0] m2d_year;
    logic [MONTH_W-1:0]           m2d_month;
    logic [DAY_OUT_W-1:0]         m2d_day;

    gmc_d2m u_d2m (
        .i_clk    (i_clk),
        .i_en     (ctl.en),
        .i_year   (r_year),
        .i_month  (r_month),
        .i_day    (r_day),
        .o_status (d2m_status),
        .o_mjd    (d2m_mjd)
    );

    gmc_m2d u_m2d (
        .i_clk       (i_clk),
        .i_en        (ctl.en),
        .i_mjd       (r_mjd),
        .o_range_bad (m2d_rbad),
        .o_year      (m2d_year),
        .o_month     (m2d_month),
        .o_day       (m2d_day)
    );

    // Result register: select the path of the request and zero unused fields.
    t_status                      n_status, r_status;
    logic signed [MJD_W-1:0]      n_mjd, r_out_mjd;
    logic signed [YEAR_OUT_W-1:0] n_year, r_out_year;
    logic [MONTH_W-1:0]           n_month, r_out_month;
    logic [DAY_OUT_W-1:0]         n_day, r_out_day;

    always_comb begin
        n_status = d2m_status;
        n_mjd    = d2m_mjd;
        n_year   = '0;
        n_month  = '0;
        n_day    = '0;
        if (ctl.req) begin
            n_mjd = '0;
            if (m2d_rbad) begin
                n_status = ST_RANGE;
            end else begin
                n_status = ST_OK;
                n_year   = m2d_year;
                n_month  = m2d_month;
                n_day    = m2d_day;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en[STG_OUT]) begin
            r_status    <= n_status;
            r_out_mjd   <= n_mjd;
            r_out_year  <= n_year;
            r_out_month <= n_month;
            r_out_day   <= n_day;
        end
    end

    assign o_rsp.status    = r_status;
    assign o_rsp.out_mjd   = r_out_mjd;
    assign o_rsp.out_year  = r_out_year;
    assign o_rsp.out_month = r_out_month;
    assign o_rsp.out_day   = r_out_day;

endmodule

// File: tb/tb_gregorian_mjd_converter.sv
`timescale 1ns / 100ps

module tb_gregorian_mjd_converter;
    import gmc_pkg::*;

    localparam bit REQ_DATE_TO_MJD = 1'b0;
    localparam bit REQ_MJD_TO_DATE = 1'b1;
    localparam int MAX_GAP         = 14;
    localparam int HOLD_CYCLES     = 300;

    typedef struct {
        logic                        req_type;
        logic signed [YEAR_IN_W-1:0] year;
        logic [MONTH_W-1:0]          month;
        logic [DAY_IN_W-1:0]         day;
        logic signed [MJD_W-1:0]     mjd;
    } t_conv_request;

    typedef struct {
        t_status                      status;
        logic signed [MJD_W-1:0]      mjd;
        logic signed [YEAR_OUT_W-1:0] year;
        logic [MONTH_W-1:0]           month;
        logic [DAY_OUT_W-1:0]         day;
    } t_conv_result;

    class t_date_conv_checker;
        t_conv_result pending_results[$];
        int unsigned  mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Hatcher's integer method; SystemVerilog division truncates toward zero as C does.
        function t_conv_result convert_date(t_conv_request r);
            t_conv_result e;
            int           month_days[1:12];
            longint       y, m, dd, len, ya, d, jd, n4, nd10, num;
            month_days = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
            e.status = ST_OK;
            e.mjd    = '0;
            e.year   = '0;
            e.month  = '0;
            e.day    = '0;
            if (r.req_type == REQ_DATE_TO_MJD) begin
                y  = r.year;
                m  = r.month;
                dd = r.day;
                if (y < -4699) begin
                    e.status = ST_BAD_YEAR;
                end else if (m < 1 || m > 12) begin
                    e.status = ST_BAD_MONTH;
                end else begin
                    len = month_days[m];
                    if (m == 2 && (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0)))
                        len = 29;
                    // A day past the month end is flagged, but its number is still given.
                    e.status = (dd < 1 || dd > len) ? ST_BAD_DAY : ST_OK;
                    ya  = y - (12 - m) / 10;
                    num = (1461 * (ya + 4712)) / 4 + (306 * ((m + 9) % 12) + 5) / 10
                        - (3 * ((ya + 4900) / 100)) / 4 + dd - 2399904;
                    e.mjd = num[MJD_W-1:0];
                end
            end else begin
                d = r.mjd;
                if (d <= -2395520 || d >= 1000000000) begin
                    e.status = ST_RANGE;
                end else begin
                    jd   = d + 2400001;
                    n4   = 4 * (jd + ((6 * ((4 * jd - 17918) / 146097)) / 4 + 1) / 2 - 37);
                    nd10 = 10 * (((n4 - 237) % 1461) / 4) + 5;
                    num  = n4 / 1461 - 4712;
                    e.year = num[YEAR_OUT_W-1:0];
                    num  = ((nd10 / 306 + 2) % 12) + 1;
                    e.month = num[MONTH_W-1:0];
                    num  = (nd10 % 306) / 10 + 1;
                    e.day = num[DAY_OUT_W-1:0];
                end
            end
            return e;
        endfunction

        function void note_request(t_conv_request r);
            pending_results = {pending_results, convert_date(r)};
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_conv_result got);
            t_conv_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: result transaction with no request pending, %s %0d",
                         $time, "expected none, actual status", got.status);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("out_mjd", want.mjd, got.mjd);
            compare_field("out_year", want.year, got.year);
            compare_field("out_month", want.month, got.month);
            compare_field("out_day", want.day, got.day);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   req_idle;
    bit   rsp_idle;
    bit   hold_results;

    t_date_conv_checker sb = new();

    gmc_req_if req_ch ();
    gmc_rsp_if rsp_ch ();

    gregorian_mjd_converter u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic t_conv_request make_date(int y, int m, int d);
        t_conv_request r;
        r.req_type = REQ_DATE_TO_MJD;
        r.year     = YEAR_IN_W'(y);
        r.month    = MONTH_W'(m);
        r.day      = DAY_IN_W'(d);
        r.mjd      = '0;
        return r;
    endfunction

    function automatic t_conv_request make_mjd(int d);
        t_conv_request r;
        r.req_type = REQ_MJD_TO_DATE;
        r.year     = '0;
        r.month    = '0;
        r.day      = '0;
        r.mjd      = MJD_W'(d);
        return r;
    endfunction

    function automatic t_conv_request random_request();
        t_conv_request r;
        int unsigned   pick;
        r.req_type = 1'($urandom_range(0, 1));
        r.year     = YEAR_IN_W'($urandom);
        r.month    = MONTH_W'($urandom);
        r.day      = DAY_IN_W'($urandom);
        r.mjd      = MJD_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            r.req_type = REQ_DATE_TO_MJD;
            if ($urandom_range(0, 3) == 0)
                r.year = YEAR_IN_W'(-4699 + $urandom_range(0, 266842));
            else
                r.year = YEAR_IN_W'(1500 + $urandom_range(0, 1000));
            r.month = MONTH_W'($urandom_range(1, 12));
            // Lean on the last days of a month so that overruns show up often.
            r.day = DAY_IN_W'($urandom_range(0, 1) ? $urandom_range(1, 31)
                                                   : $urandom_range(27, 32));
        end else if (pick < 50) begin
            r.req_type = REQ_DATE_TO_MJD;
            r.year  = YEAR_IN_W'($urandom_range(0, 1) ? 4 * $urandom_range(0, 2000) - 4000
                                                      : 100 * $urandom_range(0, 100) - 4600);
            r.month = MONTH_W'(2);
            r.day   = DAY_IN_W'($urandom_range(28, 30));
        end else if (pick < 85) begin
            r.req_type = REQ_MJD_TO_DATE;
            case ($urandom_range(0, 3))
                0: r.mjd = MJD_W'(-2395519 + $urandom_range(0, 1002395517));
                1: r.mjd = MJD_W'(-2395523 + $urandom_range(0, 6));
                2: r.mjd = MJD_W'(999999996 + $urandom_range(0, 6));
                default: r.mjd = MJD_W'(-20000 + $urandom_range(0, 100000));
            endcase
        end
        return r;
    endfunction

    task automatic send_request(input t_conv_request r);
        int unsigned gap;
        gap = req_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= r.req_type;
        req_ch.in_year  <= r.year;
        req_ch.in_month <= r.month;
        req_ch.in_day   <= r.day;
        req_ch.in_mjd   <= r.mjd;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sb.note_request(r);
    endtask

    // The first edge is taken unconditionally so that the last accepted
    // transaction is always counted before the queue is looked at.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_request(random_request());
    endtask

    initial begin
        int unsigned gap;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_results) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end
            gap = rsp_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (gap != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        t_conv_result got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.status = t_status'(rsp_ch.status);
            got.mjd    = rsp_ch.out_mjd;
            got.year   = rsp_ch.out_year;
            got.month  = rsp_ch.out_month;
            got.day    = rsp_ch.out_day;
            sb.check_result(got);
        end
    end

    initial begin
        #5_000_000;
        $display("gregorian_mjd_converter test failed");
        $finish;
    end

    initial begin
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_DATE_TO_MJD;
        req_ch.in_year  <= '0;
        req_ch.in_month <= '0;
        req_ch.in_day   <= '0;
        req_ch.in_mjd   <= '0;
        rst_n           <= 1'b0;
        req_idle        = 1'b1;
        rsp_idle        = 1'b1;
        hold_results    = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes, every error status and the leap-year rule.
        send_request(make_date(-4700, 1, 1));
        send_request(make_date(-8192, 6, 15));
        send_request(make_date(-4699, 1, 1));
        send_request(make_date(-4699, 3, 1));
        send_request(make_date(262143, 12, 31));
        send_request(make_date(2000, 0, 10));
        send_request(make_date(2000, 13, 1));
        send_request(make_date(-4700, 15, 1));
        send_request(make_date(1999, 15, 63));
        send_request(make_date(2000, 2, 29));
        send_request(make_date(1900, 2, 29));
        send_request(make_date(2023, 2, 29));
        send_request(make_date(2024, 2, 29));
        send_request(make_date(1858, 11, 17));
        send_request(make_date(2021, 4, 31));
        send_request(make_date(2021, 1, 0));
        send_request(make_date(2021, 12, 63));
        send_request(make_mjd(-2395520));
        send_request(make_mjd(-2395519));
        send_request(make_mjd(999999999));
        send_request(make_mjd(1000000000));
        send_request(make_mjd(-1073741824));
        send_request(make_mjd(1073741823));
        send_request(make_mjd(0));
        send_request(make_mjd(51544));

        send_random(500);

        req_idle = 1'b0;
        rsp_idle = 1'b0;
        send_random(400);

        // The sender waits for the pipeline to empty, then keeps offering
        // transactions while the receiver holds off long enough for the input to stall.
        drain_results();
        hold_results = 1'b1;
        send_random(60);

        req_idle = 1'b1;
        rsp_idle = 1'b0;
        send_random(280);

        req_idle = 1'b0;
        rsp_idle = 1'b1;
        send_random(280);

        drain_results();
        repeat (2 * NSTG) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("gregorian_mjd_converter test passed");
        end else begin
            $display("gregorian_mjd_converter test failed");
        end
        $finish;
    end

endmodule
